>>> rtl/core/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and codes for the deadline timer table.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 32;
  localparam int DEFAULT_ID_BITS     = 8;
  localparam int DEFAULT_FIRE_LIMIT  = 31;

  localparam int DEADLINE_W = 64;
  localparam int FIELD_ID_W = 8;

  // operation codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_DEL   = 2'd1;
  localparam logic [1:0] OP_SWEEP = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]            op;
    logic [FIELD_ID_W-1:0] timer_id;
    logic [DEADLINE_W-1:0] deadline;
    logic                  has_handler;
    logic [DEADLINE_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [1:0]            status;
    logic [FIELD_ID_W-1:0] fired_id;
    logic                  program_deadline;
    logic [DEADLINE_W-1:0] next_deadline;
    logic                  last;
  } out_item_t;

endpackage

>>> rtl/core/dtt_cmp.sv
// ----------------------------------------------------------------------------
// dtt_cmp
// Shared 64-bit unsigned less-than unit used for expiry and minimum checks.
// ----------------------------------------------------------------------------
module dtt_cmp (
  input  logic [dtt_pkg::DEADLINE_W-1:0] a,
  input  logic [dtt_pkg::DEADLINE_W-1:0] b,
  output logic                           lt
);

  assign lt = (a < b);

endmodule

>>> rtl/core/dtt_mem.sv
// ----------------------------------------------------------------------------
// dtt_mem
// Timer slot storage: deadline and id per slot, one write and one read port.
// ----------------------------------------------------------------------------
module dtt_mem #(
  parameter int DEPTH = dtt_pkg::DEFAULT_TABLE_DEPTH,
  parameter int IDW   = dtt_pkg::DEFAULT_ID_BITS,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [dtt_pkg::DEADLINE_W-1:0] wr_dl,
  input  logic [IDW-1:0]                 wr_id,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  output logic [dtt_pkg::DEADLINE_W-1:0] rd_dl,
  output logic [IDW-1:0]                 rd_id
);

  logic [dtt_pkg::DEADLINE_W-1:0] dl_mem [DEPTH];
  logic [IDW-1:0]                 id_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dl_mem[wr_addr] <= wr_dl;
      id_mem[wr_addr] <= wr_id;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_dl <= dl_mem[rd_addr];
      rd_id <= id_mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/deadline_timer_table.sv
// ----------------------------------------------------------------------------
// deadline_timer_table
// Insertion-ordered timer table with add, delete and expiry sweep.
// ----------------------------------------------------------------------------
// sequence: an op runs fetch and exam for each of the n pending slots (and keep
//   for a slot kept by a sweep), then finish; invalid adds and reserved ops skip it
// throughput: one op at a time, busy high for the scan; set by the single
//   memory read port and the shared 64-bit compare unit
// reset: synchronous active-low rst_n empties the table; results cannot stall
// ----------------------------------------------------------------------------
module deadline_timer_table #(
  parameter int TABLE_DEPTH = dtt_pkg::DEFAULT_TABLE_DEPTH,
  parameter int ID_BITS     = dtt_pkg::DEFAULT_ID_BITS,
  parameter int FIRE_LIMIT  = dtt_pkg::DEFAULT_FIRE_LIMIT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dtt_pkg::in_item_t  in_item,
  output logic               out_valid,
  output dtt_pkg::out_item_t out_item
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int FW = $clog2(FIRE_LIMIT + 1);
  localparam int DW = dtt_pkg::DEADLINE_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FETCH  = 5'b00010,
    S_EXAM   = 5'b00100,
    S_KEEP   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  dtt_pkg::out_item_t out_item_r, out_item_nxt;

  logic [1:0]         op_r, op_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [DW-1:0]      dl_r, dl_nxt;
  logic [DW-1:0]      now_r, now_nxt;
  logic [CW-1:0]      rd_r, rd_nxt;
  logic [CW-1:0]      wr_r, wr_nxt;
  logic [FW-1:0]      fired_r, fired_nxt;
  logic               found_r, found_nxt;
  logic               any_r, any_nxt;
  logic [DW-1:0]      min_r, min_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [DW-1:0]      mem_wdl;
  logic [ID_BITS-1:0] mem_wid;
  logic               mem_re;
  logic [DW-1:0]      rd_dl;
  logic [ID_BITS-1:0] rd_id;

  logic [DW-1:0]      cmp_a, cmp_b;
  logic               cmp_lt;
  logic [CW-1:0]      rd_inc;
  state_t             adv_state;

  dtt_mem #(
    .DEPTH (TABLE_DEPTH),
    .IDW   (ID_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_dl   (mem_wdl),
    .wr_id   (mem_wid),
    .rd_en   (mem_re),
    .rd_addr (rd_r[AW-1:0]),
    .rd_dl   (rd_dl),
    .rd_id   (rd_id)
  );

  dtt_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign rd_inc    = rd_r + CW'(1);
  assign adv_state = (rd_inc < count_r) ? S_FETCH : S_FINISH;

  // operand select for the shared compare unit
  always_comb begin
    cmp_a = rd_dl;
    cmp_b = min_r;
    if (state_r == S_EXAM && op_r == dtt_pkg::OP_SWEEP) begin
      cmp_a = now_r;
      cmp_b = rd_dl;
    end else if (state_r == S_FINISH) begin
      cmp_a = dl_r;
      cmp_b = min_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    op_nxt        = op_r;
    id_nxt        = id_r;
    dl_nxt        = dl_r;
    now_nxt       = now_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    fired_nxt     = fired_r;
    found_nxt     = found_r;
    any_nxt       = any_r;
    min_nxt       = min_r;
    mem_we        = 1'b0;
    mem_waddr     = wr_r[AW-1:0];
    mem_wdl       = rd_dl;
    mem_wid       = rd_id;
    mem_re        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_item.op;
          id_nxt    = ID_BITS'(in_item.timer_id);
          dl_nxt    = in_item.deadline;
          now_nxt   = in_item.now;
          rd_nxt    = '0;
          wr_nxt    = '0;
          fired_nxt = '0;
          found_nxt = 1'b0;
          any_nxt   = 1'b0;
          min_nxt   = '0;
          if (in_item.op == dtt_pkg::OP_RSVD ||
              (in_item.op == dtt_pkg::OP_ADD &&
               (in_item.deadline == '0 || !in_item.has_handler))) begin
            out_valid_nxt       = 1'b1;
            out_item_nxt.kind   = dtt_pkg::KIND_STATUS;
            out_item_nxt.status = dtt_pkg::ST_INVALID;
            out_item_nxt.last   = 1'b1;
          end else if (count_r == '0) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        mem_re    = 1'b1;
        state_nxt = S_EXAM;
      end

      S_EXAM: begin
        case (op_r)
          dtt_pkg::OP_ADD: begin
            if (rd_id == id_r) begin
              found_nxt = 1'b1;
            end
            if (!any_r || cmp_lt) begin
              min_nxt = rd_dl;
            end
            any_nxt   = 1'b1;
            rd_nxt    = rd_inc;
            state_nxt = adv_state;
          end
          dtt_pkg::OP_DEL: begin
            // first matching slot is dropped, the rest are compacted down
            if (!found_r && rd_id == id_r) begin
              found_nxt = 1'b1;
            end else begin
              mem_we = 1'b1;
              wr_nxt = wr_r + CW'(1);
            end
            rd_nxt    = rd_inc;
            state_nxt = adv_state;
          end
          dtt_pkg::OP_SWEEP: begin
            // expired when deadline <= now, i.e. not (now < deadline)
            if (!cmp_lt && fired_r < FW'(FIRE_LIMIT)) begin
              out_valid_nxt         = 1'b1;
              out_item_nxt.kind     = dtt_pkg::KIND_FIRED;
              out_item_nxt.status   = dtt_pkg::ST_OK;
              out_item_nxt.fired_id = dtt_pkg::FIELD_ID_W'(rd_id);
              fired_nxt             = fired_r + FW'(1);
              rd_nxt                = rd_inc;
              state_nxt             = adv_state;
            end else begin
              mem_we    = 1'b1;
              wr_nxt    = wr_r + CW'(1);
              state_nxt = S_KEEP;
            end
          end
          default: begin
            rd_nxt    = rd_inc;
            state_nxt = adv_state;
          end
        endcase
      end

      S_KEEP: begin
        if (!any_r || cmp_lt) begin
          min_nxt = rd_dl;
        end
        any_nxt   = 1'b1;
        rd_nxt    = rd_inc;
        state_nxt = adv_state;
      end

      S_FINISH: begin
        out_valid_nxt     = 1'b1;
        out_item_nxt.last = 1'b1;
        state_nxt         = S_IDLE;
        case (op_r)
          dtt_pkg::OP_ADD: begin
            out_item_nxt.kind = dtt_pkg::KIND_STATUS;
            if (found_r) begin
              out_item_nxt.status = dtt_pkg::ST_INVALID;
            end else if (count_r == CW'(TABLE_DEPTH)) begin
              out_item_nxt.status = dtt_pkg::ST_FULL;
            end else begin
              mem_we                        = 1'b1;
              mem_waddr                     = count_r[AW-1:0];
              mem_wdl                       = dl_r;
              mem_wid                       = id_r;
              count_nxt                     = count_r + CW'(1);
              out_item_nxt.status           = dtt_pkg::ST_OK;
              out_item_nxt.program_deadline = 1'b1;
              out_item_nxt.next_deadline    = (!any_r || cmp_lt) ? dl_r : min_r;
            end
          end
          dtt_pkg::OP_DEL: begin
            out_item_nxt.kind = dtt_pkg::KIND_STATUS;
            if (found_r) begin
              out_item_nxt.status = dtt_pkg::ST_OK;
              count_nxt           = wr_r;
            end else begin
              out_item_nxt.status = dtt_pkg::ST_NOT_FOUND;
            end
          end
          dtt_pkg::OP_SWEEP: begin
            count_nxt                     = wr_r;
            out_item_nxt.kind             = dtt_pkg::KIND_DONE;
            out_item_nxt.status           = dtt_pkg::ST_OK;
            out_item_nxt.program_deadline = any_r;
            out_item_nxt.next_deadline    = any_r ? min_r : '0;
          end
          default: begin
            out_item_nxt.kind   = dtt_pkg::KIND_STATUS;
            out_item_nxt.status = dtt_pkg::ST_INVALID;
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    dl_r       <= dl_nxt;
    now_r      <= now_nxt;
    rd_r       <= rd_nxt;
    wr_r       <= wr_nxt;
    fired_r    <= fired_nxt;
    found_r    <= found_nxt;
    any_r      <= any_nxt;
    min_r      <= min_nxt;
  end

`ifndef SYNTHESIS
  // the final beat of an op leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.last |-> state_r == S_IDLE)
    else $error("final beat while sequencer still active");

  // fired beats only come out mid-sweep
  a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.kind == dtt_pkg::KIND_FIRED |-> busy && !out_item_r.last)
    else $error("fired beat outside a sweep");

  // compaction never overtakes the scan
  a_wr_behind: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXAM |-> wr_r <= rd_r && rd_r < count_r)
    else $error("write pointer ahead of read pointer");

  // table occupancy never exceeds depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINISH |=> count_r <= CW'(TABLE_DEPTH))
    else $error("slot count overflow");
`endif

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the deadline timer table. A scoreboard keeps its
// own copy of the timer list, predicts the status, fired and done beats for
// every accepted operation and checks each output beat in order. Stimulus is
// a directed opening followed by random add/delete/sweep traffic with table
// fill-and-flush episodes, sent in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = dtt_pkg::DEFAULT_TABLE_DEPTH;
  localparam int FIRE_CAP    = dtt_pkg::DEFAULT_FIRE_LIMIT;
  localparam int ITEM_TARGET = 210;
  localparam int DRAIN_CYCLES = 200;

  class timer_scoreboard;
    logic [63:0]        dl_tab[TABLE_SLOTS];
    logic [7:0]         id_tab[TABLE_SLOTS];
    int                 slot_count;
    dtt_pkg::out_item_t pending[$];
    int                 errors;

    function new();
      slot_count = 0;
      errors     = 0;
    endfunction

    function int find(logic [7:0] id);
      for (int i = 0; i < slot_count; i++) begin
        if (id_tab[i] == id) return i;
      end
      return -1;
    endfunction

    function void drop_slot(int pos);
      for (int i = pos; i + 1 < slot_count; i++) begin
        dl_tab[i] = dl_tab[i+1];
        id_tab[i] = id_tab[i+1];
      end
      slot_count--;
    endfunction

    function bit earliest(output logic [63:0] best);
      best = '0;
      for (int i = 0; i < slot_count; i++) begin
        if (i == 0 || dl_tab[i] < best) best = dl_tab[i];
      end
      return slot_count > 0;
    endfunction

    function void queue_result(logic [1:0] kind, logic [1:0] status, logic [7:0] fid,
                               logic prog, logic [63:0] next, logic last);
      dtt_pkg::out_item_t r;
      r.kind             = kind;
      r.status           = status;
      r.fired_id         = fid;
      r.program_deadline = prog;
      r.next_deadline    = next;
      r.last             = last;
      pending.push_back(r);
    endfunction

    // accepted input beat: update the table and queue what it should produce
    function void note_op(dtt_pkg::in_item_t it);
      logic [63:0] nxt;
      int pos;
      int fired;
      int i;
      case (it.op)
        dtt_pkg::OP_ADD: begin
          if (it.deadline == '0 || !it.has_handler || find(it.timer_id) >= 0) begin
            queue_result(dtt_pkg::KIND_STATUS, dtt_pkg::ST_INVALID, '0, 1'b0, '0, 1'b1);
          end else if (slot_count >= TABLE_SLOTS) begin
            queue_result(dtt_pkg::KIND_STATUS, dtt_pkg::ST_FULL, '0, 1'b0, '0, 1'b1);
          end else begin
            dl_tab[slot_count] = it.deadline;
            id_tab[slot_count] = it.timer_id;
            slot_count++;
            void'(earliest(nxt));
            queue_result(dtt_pkg::KIND_STATUS, dtt_pkg::ST_OK, '0, 1'b1, nxt, 1'b1);
          end
        end
        dtt_pkg::OP_DEL: begin
          pos = find(it.timer_id);
          if (pos < 0) begin
            queue_result(dtt_pkg::KIND_STATUS, dtt_pkg::ST_NOT_FOUND, '0, 1'b0, '0, 1'b1);
          end else begin
            drop_slot(pos);
            queue_result(dtt_pkg::KIND_STATUS, dtt_pkg::ST_OK, '0, 1'b0, '0, 1'b1);
          end
        end
        dtt_pkg::OP_SWEEP: begin
          fired = 0;
          i = 0;
          while (i < slot_count && fired < FIRE_CAP) begin
            if (dl_tab[i] <= it.now) begin
              queue_result(dtt_pkg::KIND_FIRED, dtt_pkg::ST_OK, id_tab[i], 1'b0, '0, 1'b0);
              fired++;
              drop_slot(i);
            end else begin
              i++;
            end
          end
          if (earliest(nxt))
            queue_result(dtt_pkg::KIND_DONE, dtt_pkg::ST_OK, '0, 1'b1, nxt, 1'b1);
          else
            queue_result(dtt_pkg::KIND_DONE, dtt_pkg::ST_OK, '0, 1'b0, '0, 1'b1);
        end
        default: begin
          queue_result(dtt_pkg::KIND_STATUS, dtt_pkg::ST_INVALID, '0, 1'b0, '0, 1'b1);
        end
      endcase
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(dtt_pkg::out_item_t got);
      dtt_pkg::out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      cmp("kind", want.kind, got.kind);
      cmp("status", want.status, got.status);
      cmp("fired_id", want.fired_id, got.fired_id);
      cmp("program_deadline", want.program_deadline, got.program_deadline);
      cmp("next_deadline", want.next_deadline, got.next_deadline);
      cmp("last", want.last, got.last);
    endfunction

    function void flag_leftovers();
      foreach (pending[k]) begin
        $display("%0t: missing beat: expected %0h, actual none", $time, pending[k]);
        errors++;
      end
    endfunction
  endclass

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               start   = 1'b0;
  logic               busy;
  dtt_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  dtt_pkg::out_item_t out_item;

  timer_scoreboard sb = new();

  logic [63:0] tick;
  int          sent;
  int          burst_left;

  deadline_timer_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic dtt_pkg::in_item_t noise();
    dtt_pkg::in_item_t it;
    it.op          = 2'($urandom_range(0, 3));
    it.timer_id    = 8'($urandom_range(0, 255));
    it.deadline    = rand64();
    it.has_handler = 1'($urandom_range(0, 1));
    it.now         = rand64();
    return it;
  endfunction

  function automatic dtt_pkg::in_item_t item_of(logic [1:0] op, logic [7:0] id,
                                                logic [63:0] dl, logic hh,
                                                logic [63:0] now);
    dtt_pkg::in_item_t it;
    it.op          = op;
    it.timer_id    = id;
    it.deadline    = dl;
    it.has_handler = hh;
    it.now         = now;
    return it;
  endfunction

  function automatic logic [7:0] fresh_id();
    logic [7:0] id;
    do id = 8'($urandom_range(0, 255)); while (sb.find(id) >= 0);
    return id;
  endfunction

  // hold the beat until the block takes it, then maybe pause between bursts
  task automatic send_item(dtt_pkg::in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_op(it);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                                : $urandom_range(1, 10);
    end
  endtask

  task automatic directed_ops();
    send_item(item_of(dtt_pkg::OP_SWEEP, 8'h00, 64'd0, 1'b0, 64'd0));
    send_item(item_of(dtt_pkg::OP_DEL, 8'h05, 64'd0, 1'b0, 64'd0));
    send_item(item_of(dtt_pkg::OP_ADD, 8'h00, 64'd0, 1'b1, 64'd0));
    send_item(item_of(dtt_pkg::OP_ADD, 8'h01, 64'd100, 1'b0, 64'd0));
    send_item(item_of(dtt_pkg::OP_ADD, 8'h00, '1, 1'b1, 64'd0));
    send_item(item_of(dtt_pkg::OP_ADD, 8'hff, 64'd1, 1'b1, '1));
    // same id again is a duplicate
    send_item(item_of(dtt_pkg::OP_ADD, 8'hff, 64'd50, 1'b1, 64'd0));
    send_item(item_of(dtt_pkg::OP_ADD, 8'h5a, 64'd1000, 1'b1, 64'd0));
    send_item(item_of(dtt_pkg::OP_ADD, 8'ha5, 64'd500, 1'b1, 64'd0));
    send_item(item_of(dtt_pkg::OP_RSVD, 8'hff, '1, 1'b1, '1));
    send_item(item_of(dtt_pkg::OP_SWEEP, 8'h00, 64'd0, 1'b0, 64'd0));
    // deadline equal to now fires
    send_item(item_of(dtt_pkg::OP_SWEEP, 8'h00, 64'd0, 1'b0, 64'd1));
    send_item(item_of(dtt_pkg::OP_DEL, 8'h5a, 64'd0, 1'b0, 64'd0));
    send_item(item_of(dtt_pkg::OP_DEL, 8'h5a, 64'd0, 1'b0, 64'd0));
    send_item(item_of(dtt_pkg::OP_SWEEP, 8'h00, 64'd0, 1'b0, 64'd500));
    send_item(item_of(dtt_pkg::OP_SWEEP, 8'h00, 64'd0, 1'b0, '1));
    send_item(item_of(dtt_pkg::OP_ADD, 8'h07, 64'h8000_0000_0000_0000, 1'b1, 64'd0));
    send_item(item_of(dtt_pkg::OP_ADD, 8'h80, 64'h7fff_ffff_ffff_ffff, 1'b1, 64'd0));
    send_item(item_of(dtt_pkg::OP_DEL, 8'h07, 64'd0, 1'b0, 64'd0));
    send_item(item_of(dtt_pkg::OP_SWEEP, 8'h00, 64'd0, 1'b0, 64'h7fff_ffff_ffff_fffe));
    send_item(item_of(dtt_pkg::OP_DEL, 8'h80, 64'd0, 1'b0, 64'd0));
  endtask

  // fill the table past full, then flush; an all-ones timestamp hits the fire cap
  task automatic fill_and_flush(bit max_now);
    dtt_pkg::in_item_t it;
    int over;
    over = 0;
    while (over < 2) begin
      it = noise();
      it.op          = dtt_pkg::OP_ADD;
      it.has_handler = 1'b1;
      it.timer_id    = fresh_id();
      it.deadline    = tick + $urandom_range(1, 400);
      if (sb.slot_count >= TABLE_SLOTS) over++;
      send_item(it);
    end
    it = noise();
    it.op  = dtt_pkg::OP_SWEEP;
    it.now = max_now ? '1 : tick + 1000;
    send_item(it);
    it = noise();
    it.op  = dtt_pkg::OP_SWEEP;
    it.now = '1;
    send_item(it);
    tick += 1000;
  endtask

  task automatic random_op();
    dtt_pkg::in_item_t it;
    int sel;
    int r;
    it  = noise();
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      it.op          = dtt_pkg::OP_ADD;
      it.timer_id    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 23));
      it.has_handler = ($urandom_range(0, 19) != 0);
      r = $urandom_range(0, 29);
      if (r == 0) it.deadline = '0;
      else if (r < 4) it.deadline = rand64();
      else it.deadline = tick + $urandom_range(1, 3000);
    end else if (sel < 65) begin
      it.op = dtt_pkg::OP_DEL;
      if ($urandom_range(0, 2) != 0 && sb.slot_count > 0)
        it.timer_id = sb.id_tab[$urandom_range(0, sb.slot_count - 1)];
      else
        it.timer_id = 8'($urandom_range(0, 31));
    end else if (sel < 92) begin
      it.op = dtt_pkg::OP_SWEEP;
      r = $urandom_range(0, 19);
      if (r == 0) it.now = '0;
      else if (r == 1) it.now = '1;
      else if (r == 2) it.now = rand64();
      else it.now = tick + $urandom_range(0, 2000);
      tick += $urandom_range(0, 800);
    end else if (sel < 96) begin
      it.op = dtt_pkg::OP_RSVD;
    end
    send_item(it);
  endtask

  initial begin
    bit filled_once;
    bit filled_twice;
    int waited;
    sent         = 0;
    burst_left   = 4;
    filled_once  = 1'b0;
    filled_twice = 1'b0;
    tick         = {32'h1, $urandom};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_ops();
    while (sent < ITEM_TARGET) begin
      if (!filled_once && sent >= 60) begin
        filled_once = 1'b1;
        fill_and_flush(1'b1);
      end else if (!filled_twice && sent >= 150) begin
        filled_twice = 1'b1;
        fill_and_flush(1'b0);
      end else begin
        random_op();
      end
    end
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    // catch any stray beats after the last expected one
    waited = 0;
    while (waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
rtl/core/dtt_pkg.sv
rtl/core/dtt_cmp.sv
rtl/core/dtt_mem.sv
rtl/core/deadline_timer_table.sv
bench/tb_top.sv
